// ===== sv/drlkr_pkg.sv =====
// shared constants, types and the control program of the dual-role layer key remapper
package drlkr_pkg;

  localparam int FIFO_DEPTH = 8;
  localparam int CODE_COUNT = 256;

  localparam int CODE_W  = 8;
  localparam int VAL_W   = 2;
  localparam int OP_W    = 2;
  localparam int CODE_AW = (CODE_COUNT > 1) ? $clog2(CODE_COUNT) : 1;
  localparam int FIFO_AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W   = $clog2(FIFO_DEPTH + 1);
  localparam int STEP_W  = 5;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;

  // register index, taken from the word address bits of paddr
  localparam logic [CFG_AW-3:0] REG_LAYER_KEY = '0;

  // input opcodes
  localparam logic [OP_W-1:0] OP_KEY   = 2'd0;
  localparam logic [OP_W-1:0] OP_REMAP = 2'd1;
  localparam logic [OP_W-1:0] OP_LAYER = 2'd2;
  localparam logic [OP_W-1:0] OP_MOD   = 2'd3;

  // layer key modes
  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_HELD   = 2'd1;
  localparam logic [1:0] MODE_DELAY  = 2'd2;
  localparam logic [1:0] MODE_MAPPED = 2'd3;

  // sequencing kinds
  localparam logic [2:0] SQ_NEXT   = 3'd0;
  localparam logic [2:0] SQ_JUMP   = 3'd1;
  localparam logic [2:0] SQ_JIF    = 3'd2;
  localparam logic [2:0] SQ_DISP   = 3'd3;
  localparam logic [2:0] SQ_ACCEPT = 3'd4;
  localparam logic [2:0] SQ_END    = 3'd5;

  // jump conditions
  localparam logic [1:0] C_TBL     = 2'd0;
  localparam logic [1:0] C_SENT    = 2'd1;
  localparam logic [1:0] C_NO_SEND = 2'd2;
  localparam logic [1:0] C_COUNT_Z = 2'd3;

  // emitted code sources
  localparam logic [2:0] CS_CODE  = 3'd0;
  localparam logic [2:0] CS_REMAP = 3'd1;
  localparam logic [2:0] CS_LAYER = 3'd2;
  localparam logic [2:0] CS_LKEY  = 3'd3;
  localparam logic [2:0] CS_FIFO  = 3'd4;

  // emitted value sources
  localparam logic [1:0] VS_IN   = 2'd0;
  localparam logic [1:0] VS_ONE  = 2'd1;
  localparam logic [1:0] VS_ZERO = 2'd2;

  // pending queue operations
  localparam logic [1:0] FO_NONE  = 2'd0;
  localparam logic [1:0] FO_PUSH  = 2'd1;
  localparam logic [1:0] FO_POP   = 2'd2;
  localparam logic [1:0] FO_CLEAR = 2'd3;

  // program addresses
  localparam logic [STEP_W-1:0] S_IDLE  = STEP_W'(0);
  localparam logic [STEP_W-1:0] S_LOOK  = STEP_W'(1);
  localparam logic [STEP_W-1:0] S_DISP  = STEP_W'(2);
  localparam logic [STEP_W-1:0] S_END   = STEP_W'(3);
  localparam logic [STEP_W-1:0] S_WR    = STEP_W'(4);
  localparam logic [STEP_W-1:0] S_REMAP = STEP_W'(5);
  localparam logic [STEP_W-1:0] S_ENTER = STEP_W'(6);
  localparam logic [STEP_W-1:0] S_PASS  = STEP_W'(7);
  localparam logic [STEP_W-1:0] S_HLK0  = STEP_W'(8);
  localparam logic [STEP_W-1:0] S_HLK1  = STEP_W'(9);
  localparam logic [STEP_W-1:0] S_HLK2  = STEP_W'(10);
  localparam logic [STEP_W-1:0] S_HMD   = STEP_W'(11);
  localparam logic [STEP_W-1:0] S_HUM0  = STEP_W'(12);
  localparam logic [STEP_W-1:0] S_HUM1  = STEP_W'(13);
  localparam logic [STEP_W-1:0] S_DLK0  = STEP_W'(14);
  localparam logic [STEP_W-1:0] S_DLK1  = STEP_W'(15);
  localparam logic [STEP_W-1:0] S_DLK2  = STEP_W'(16);
  localparam logic [STEP_W-1:0] S_DLK3  = STEP_W'(17);
  localparam logic [STEP_W-1:0] S_DMD0  = STEP_W'(18);
  localparam logic [STEP_W-1:0] S_DMD1  = STEP_W'(19);
  localparam logic [STEP_W-1:0] S_DMD2  = STEP_W'(20);
  localparam logic [STEP_W-1:0] S_LQV   = STEP_W'(21);
  localparam logic [STEP_W-1:0] S_DMU0  = STEP_W'(22);
  localparam logic [STEP_W-1:0] S_DMU1  = STEP_W'(23);
  localparam logic [STEP_W-1:0] S_DMU2  = STEP_W'(24);
  localparam logic [STEP_W-1:0] S_DUM   = STEP_W'(25);
  localparam logic [STEP_W-1:0] S_MLK0  = STEP_W'(26);
  localparam logic [STEP_W-1:0] S_MLK1  = STEP_W'(27);

  typedef struct packed {
    logic [2:0]        seq;
    logic [1:0]        cond;
    logic [STEP_W-1:0] target;
    logic              emit;
    logic [2:0]        code_src;
    logic [1:0]        val_src;
    logic [1:0]        fifo_op;
    logic              mode_we;
    logic [1:0]        mode_val;
    logic              sent_set;
    logic              sent_clr;
    logic              rd_head;
    logic              tbl_we;
  } ctrl_t;

  typedef struct packed {
    logic       table_op;
    logic       remap_nz;
    logic       is_layer;
    logic       down;
    logic       mapped;
    logic       is_mod;
    logic [1:0] mode;
    logic       sent;
    logic       count_zero;
    logic       out_block;
  } stat_t;

  function automatic logic code_ok(input logic [CODE_W-1:0] code);
    return 32'(code) < 32'(CODE_COUNT);
  endfunction

  function automatic logic [CODE_AW-1:0] code_addr(input logic [CODE_W-1:0] code);
    logic [CODE_W+CODE_AW-1:0] ext;
    ext = (CODE_W + CODE_AW)'(code);
    return ext[CODE_AW-1:0];
  endfunction

  // control store: one word per step
  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t w;
    w = '0;
    unique case (step)
      S_IDLE: w.seq = SQ_ACCEPT;
      S_LOOK: begin
        w.seq = SQ_JIF; w.cond = C_TBL; w.target = S_WR;
      end
      S_DISP: w.seq = SQ_DISP;
      S_END:  w.seq = SQ_END;
      S_WR: begin
        w.tbl_we = 1'b1; w.seq = SQ_JUMP; w.target = S_END;
      end
      S_REMAP: begin
        w.emit = 1'b1; w.code_src = CS_REMAP; w.val_src = VS_IN;
        w.seq = SQ_JUMP; w.target = S_END;
      end
      S_ENTER: begin
        w.mode_we = 1'b1; w.mode_val = MODE_HELD; w.sent_clr = 1'b1;
        w.fifo_op = FO_CLEAR; w.seq = SQ_JUMP; w.target = S_END;
      end
      S_PASS: begin
        w.emit = 1'b1; w.code_src = CS_CODE; w.val_src = VS_IN;
        w.seq = SQ_JUMP; w.target = S_END;
      end
      S_HLK0: begin
        w.mode_we = 1'b1; w.mode_val = MODE_IDLE;
        w.seq = SQ_JIF; w.cond = C_SENT; w.target = S_HLK2;
      end
      S_HLK1: begin
        w.emit = 1'b1; w.code_src = CS_LKEY; w.val_src = VS_ONE;
      end
      S_HLK2: begin
        w.emit = 1'b1; w.code_src = CS_LKEY; w.val_src = VS_ZERO;
        w.seq = SQ_JUMP; w.target = S_END;
      end
      S_HMD: begin
        w.mode_we = 1'b1; w.mode_val = MODE_DELAY; w.fifo_op = FO_PUSH;
        w.seq = SQ_JUMP; w.target = S_END;
      end
      S_HUM0: begin
        w.seq = SQ_JIF; w.cond = C_NO_SEND; w.target = S_PASS;
      end
      S_HUM1: begin
        w.emit = 1'b1; w.code_src = CS_LKEY; w.val_src = VS_ONE; w.sent_set = 1'b1;
        w.seq = SQ_JUMP; w.target = S_PASS;
      end
      S_DLK0: begin
        w.mode_we = 1'b1; w.mode_val = MODE_IDLE;
        w.seq = SQ_JIF; w.cond = C_SENT; w.target = S_DLK2;
      end
      S_DLK1: begin
        w.emit = 1'b1; w.code_src = CS_LKEY; w.val_src = VS_ONE;
      end
      S_DLK2: begin
        w.seq = SQ_JIF; w.cond = C_COUNT_Z; w.target = S_HLK2;
      end
      S_DLK3: begin
        w.emit = 1'b1; w.code_src = CS_FIFO; w.val_src = VS_ONE; w.fifo_op = FO_POP;
        w.seq = SQ_JUMP; w.target = S_DLK2;
      end
      S_DMD0: begin
        w.mode_we = 1'b1; w.mode_val = MODE_MAPPED; w.rd_head = 1'b1;
        w.seq = SQ_JIF; w.cond = C_COUNT_Z; w.target = S_DMD2;
      end
      S_DMD1: begin
        w.emit = 1'b1; w.code_src = CS_LAYER; w.val_src = VS_ONE;
      end
      S_DMD2: w.fifo_op = FO_PUSH;
      S_LQV: begin
        w.emit = 1'b1; w.code_src = CS_LAYER; w.val_src = VS_IN;
        w.seq = SQ_JUMP; w.target = S_END;
      end
      S_DMU0: begin
        w.mode_we = 1'b1; w.mode_val = MODE_MAPPED; w.rd_head = 1'b1;
        w.seq = SQ_JIF; w.cond = C_COUNT_Z; w.target = S_DMU2;
      end
      S_DMU1: begin
        w.emit = 1'b1; w.code_src = CS_LAYER; w.val_src = VS_ONE; w.fifo_op = FO_POP;
        w.seq = SQ_JUMP; w.target = S_DMU0;
      end
      S_DMU2: begin
        w.seq = SQ_JUMP; w.target = S_LQV;
      end
      S_DUM: begin
        w.mode_we = 1'b1; w.mode_val = MODE_MAPPED;
        w.emit = 1'b1; w.code_src = CS_CODE; w.val_src = VS_IN;
        w.seq = SQ_JUMP; w.target = S_END;
      end
      S_MLK0: begin
        w.mode_we = 1'b1; w.mode_val = MODE_IDLE; w.rd_head = 1'b1;
        w.seq = SQ_JIF; w.cond = C_COUNT_Z; w.target = S_END;
      end
      S_MLK1: begin
        w.emit = 1'b1; w.code_src = CS_LAYER; w.val_src = VS_ZERO; w.fifo_op = FO_POP;
        w.seq = SQ_JUMP; w.target = S_MLK0;
      end
      default: begin
        w.seq = SQ_JUMP; w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== sv/drlkr_ram.sv =====
// generic single-write, single-read ram with registered read data
module drlkr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/drlkr_tables.sv =====
// remap, layer and modifier tables, zeroed by a clearing pass after reset
module drlkr_tables import drlkr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [CODE_W-1:0] rd_code,
  input  logic              wr_en,
  input  logic [OP_W-1:0]   wr_op,
  input  logic [CODE_W-1:0] wr_code,
  input  logic [CODE_W-1:0] wr_data,
  output logic [CODE_W-1:0] remap_q,
  output logic [CODE_W-1:0] layer_q,
  output logic              mod_q,
  output logic              busy
);

  logic [CODE_AW-1:0] rd_addr;
  logic [CODE_AW-1:0] wr_addr;
  logic               wr_ok;
  logic               we_remap;
  logic               we_layer;
  logic               we_mod;
  logic               clr_busy_r;
  logic               clr_busy_nxt;
  logic [CODE_AW-1:0] clr_addr_r;
  logic [CODE_AW-1:0] clr_addr_nxt;
  logic [CODE_AW-1:0] ram_waddr;
  logic [CODE_W-1:0]  ram_wdata;
  logic               rd_ok_r;
  logic [CODE_W-1:0]  remap_rd;
  logic [CODE_W-1:0]  layer_rd;
  logic               mod_rd;

  assign rd_addr  = code_addr(rd_code);
  assign wr_addr  = code_addr(wr_code);
  assign wr_ok    = code_ok(wr_code);
  assign we_remap = wr_en && wr_ok && (wr_op == OP_REMAP);
  assign we_layer = wr_en && wr_ok && (wr_op == OP_LAYER);
  assign we_mod   = wr_en && wr_ok && (wr_op == OP_MOD);

  // clearing pass after reset: one entry a cycle, over every table entry
  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_busy_r) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (clr_addr_r == CODE_AW'(CODE_COUNT - 1)) clr_busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  assign busy      = clr_busy_r;
  assign ram_waddr = clr_busy_r ? clr_addr_r : wr_addr;
  assign ram_wdata = clr_busy_r ? '0 : wr_data;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_ok_r <= code_ok(rd_code);
    end
  end

  drlkr_ram #(.WIDTH(CODE_W), .DEPTH(CODE_COUNT)) u_remap (
    .clk(clk), .we(clr_busy_r || we_remap), .waddr(ram_waddr), .wdata(ram_wdata),
    .re(rd_en), .raddr(rd_addr), .rdata(remap_rd)
  );

  drlkr_ram #(.WIDTH(CODE_W), .DEPTH(CODE_COUNT)) u_layer (
    .clk(clk), .we(clr_busy_r || we_layer), .waddr(ram_waddr), .wdata(ram_wdata),
    .re(rd_en), .raddr(rd_addr), .rdata(layer_rd)
  );

  drlkr_ram #(.WIDTH(1), .DEPTH(CODE_COUNT)) u_mod (
    .clk(clk), .we(clr_busy_r || we_mod), .waddr(ram_waddr), .wdata(ram_wdata[0]),
    .re(rd_en), .raddr(rd_addr), .rdata(mod_rd)
  );

  assign remap_q = rd_ok_r ? remap_rd : '0;
  assign layer_q = rd_ok_r ? layer_rd : '0;
  assign mod_q   = rd_ok_r && mod_rd;

endmodule

// ===== sv/drlkr_seq.sv =====
// microprogram sequencer: step counter, control store, jumps and dispatch
module drlkr_seq import drlkr_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  logic  busy,
  input  stat_t stat,
  output ctrl_t ctrl,
  output logic  advance,
  output logic  accept,
  output logic  in_stall
);

  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] step_nxt;
  logic [STEP_W-1:0] step_inc;
  logic [STEP_W-1:0] disp;
  logic              cond_hit;
  logic              blocked;

  assign ctrl     = ucode(step_r);
  assign step_inc = step_r + 1'b1;

  always_comb begin
    case (ctrl.cond)
      C_TBL:     cond_hit = stat.table_op;
      C_SENT:    cond_hit = stat.sent;
      C_NO_SEND: cond_hit = !(!stat.is_mod && stat.down && !stat.sent);
      C_COUNT_Z: cond_hit = stat.count_zero;
      default:   cond_hit = 1'b0;
    endcase
  end

  // entry point by remap hit, mode and key class
  always_comb begin
    if (stat.remap_nz) begin
      disp = S_REMAP;
    end else begin
      unique case (stat.mode)
        MODE_IDLE: disp = (stat.is_layer && stat.down) ? S_ENTER : S_PASS;
        MODE_HELD: begin
          if (stat.is_layer)    disp = stat.down ? S_END : S_HLK0;
          else if (stat.mapped) disp = stat.down ? S_HMD : S_PASS;
          else                  disp = S_HUM0;
        end
        MODE_DELAY: begin
          if (stat.is_layer)    disp = stat.down ? S_END : S_DLK0;
          else if (stat.mapped) disp = stat.down ? S_DMD0 : S_DMU0;
          else                  disp = S_DUM;
        end
        MODE_MAPPED: begin
          if (stat.is_layer)    disp = stat.down ? S_END : S_MLK0;
          else if (stat.mapped) disp = S_DMD2;
          else                  disp = S_PASS;
        end
        default: disp = S_END;
      endcase
    end
  end

  assign blocked  = (ctrl.emit || (ctrl.seq == SQ_END)) && stat.out_block;
  assign in_stall = (ctrl.seq != SQ_ACCEPT) || busy;
  assign accept   = (ctrl.seq == SQ_ACCEPT) && in_valid && !busy;
  assign advance  = (ctrl.seq == SQ_ACCEPT) ? (in_valid && !busy) : !blocked;

  always_comb begin
    unique case (ctrl.seq)
      SQ_NEXT:   step_nxt = step_inc;
      SQ_JUMP:   step_nxt = ctrl.target;
      SQ_JIF:    step_nxt = cond_hit ? ctrl.target : step_inc;
      SQ_DISP:   step_nxt = disp;
      SQ_ACCEPT: step_nxt = step_inc;
      SQ_END:    step_nxt = S_IDLE;
      default:   step_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= S_IDLE;
    end else if (advance) begin
      step_r <= step_nxt;
    end
  end

endmodule

// ===== sv/drlkr_dp.sv =====
// datapath: latched event, mode state, pending queue, hold stage and output register
module drlkr_dp import drlkr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [OP_W-1:0]   in_opcode,
  input  logic [CODE_W-1:0] in_key_code,
  input  logic [VAL_W-1:0]  in_key_value,
  input  logic [CODE_W-1:0] in_table_data,
  input  logic              accept,
  input  logic              advance,
  input  ctrl_t             ctrl,
  input  logic [CODE_W-1:0] layer_key,
  input  logic [CODE_W-1:0] remap_q,
  input  logic [CODE_W-1:0] layer_q,
  input  logic              mod_q,
  output logic              rd_en,
  output logic [CODE_W-1:0] rd_code,
  output logic              wr_en,
  output logic [OP_W-1:0]   wr_op,
  output logic [CODE_W-1:0] wr_code,
  output logic [CODE_W-1:0] wr_data,
  output stat_t             stat,
  input  logic              out_stall,
  output logic              out_valid,
  output logic [CODE_W-1:0] out_code,
  output logic [VAL_W-1:0]  out_value,
  output logic              out_last
);

  localparam int SUM_W = CNT_W + 1;

  logic [OP_W-1:0]    op_r;
  logic [CODE_W-1:0]  code_r;
  logic [VAL_W-1:0]   val_r;
  logic [CODE_W-1:0]  data_r;
  logic [1:0]         mode_r;
  logic [1:0]         mode_nxt;
  logic               sent_r;
  logic               sent_nxt;
  logic [CODE_W-1:0]  fifo_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] head_r;
  logic [FIFO_AW-1:0] head_nxt;
  logic [FIFO_AW-1:0] head_inc;
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;
  logic [SUM_W-1:0]   wr_sum;
  logic [SUM_W-1:0]   wr_wrap;
  logic [FIFO_AW-1:0] wr_idx;
  logic               full;
  logic               push_en;
  logic [CODE_W-1:0]  head_code;
  logic               hold_v_r;
  logic               hold_v_nxt;
  logic [CODE_W-1:0]  hold_code_r;
  logic [VAL_W-1:0]   hold_val_r;
  logic [CODE_W-1:0]  emit_code;
  logic [VAL_W-1:0]   emit_val;
  logic               do_emit;
  logic               do_end;
  logic               load_out;
  logic               out_valid_r;
  logic               out_valid_nxt;
  logic [CODE_W-1:0]  out_code_r;
  logic [VAL_W-1:0]   out_value_r;
  logic               out_last_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_opcode;
      code_r <= in_key_code;
      val_r  <= in_key_value;
      data_r <= in_table_data;
    end
  end

  assign head_code = fifo_r[head_r];

  // table port
  assign rd_en   = advance;
  assign rd_code = ctrl.rd_head ? head_code : code_r;
  assign wr_en   = advance && ctrl.tbl_we;
  assign wr_op   = op_r;
  assign wr_code = code_r;
  assign wr_data = data_r;

  // pending queue, circular over its depth
  assign full     = (count_r == CNT_W'(FIFO_DEPTH));
  assign push_en  = advance && (ctrl.fifo_op == FO_PUSH) && (val_r != '0) && !full;
  assign wr_sum   = SUM_W'(head_r) + SUM_W'(count_r);
  assign wr_wrap  = (wr_sum >= SUM_W'(FIFO_DEPTH)) ? wr_sum - SUM_W'(FIFO_DEPTH) : wr_sum;
  assign wr_idx   = wr_wrap[FIFO_AW-1:0];
  assign head_inc = (head_r == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : head_r + 1'b1;

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    case (ctrl.fifo_op)
      FO_PUSH: begin
        if (push_en) count_nxt = count_r + 1'b1;
      end
      FO_POP: begin
        if (advance) begin
          head_nxt  = head_inc;
          count_nxt = count_r - 1'b1;
        end
      end
      FO_CLEAR: begin
        if (advance) begin
          head_nxt  = '0;
          count_nxt = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      fifo_r[wr_idx] <= code_r;
    end
  end

  always_comb begin
    mode_nxt = mode_r;
    sent_nxt = sent_r;
    if (advance && ctrl.mode_we) mode_nxt = ctrl.mode_val;
    if (advance && ctrl.sent_set) sent_nxt = 1'b1;
    if (advance && ctrl.sent_clr) sent_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      sent_r  <= 1'b0;
      head_r  <= '0;
      count_r <= '0;
    end else begin
      mode_r  <= mode_nxt;
      sent_r  <= sent_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_comb begin
    case (ctrl.code_src)
      CS_CODE:  emit_code = code_r;
      CS_REMAP: emit_code = remap_q;
      CS_LAYER: emit_code = layer_q;
      CS_LKEY:  emit_code = layer_key;
      CS_FIFO:  emit_code = head_code;
      default:  emit_code = code_r;
    endcase
    case (ctrl.val_src)
      VS_IN:   emit_val = val_r;
      VS_ONE:  emit_val = VAL_W'(1);
      VS_ZERO: emit_val = '0;
      default: emit_val = val_r;
    endcase
  end

  // one result is held back so the end step can mark it last
  assign do_emit  = advance && ctrl.emit;
  assign do_end   = advance && (ctrl.seq == SQ_END);
  assign load_out = (do_emit || do_end) && hold_v_r;

  always_comb begin
    hold_v_nxt = hold_v_r;
    if (do_emit) hold_v_nxt = 1'b1;
    else if (do_end) hold_v_nxt = 1'b0;
    out_valid_nxt = out_valid_r;
    if (load_out) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      hold_v_r    <= hold_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_emit) begin
      hold_code_r <= emit_code;
      hold_val_r  <= emit_val;
    end
    if (load_out) begin
      out_code_r  <= hold_code_r;
      out_value_r <= hold_val_r;
      out_last_r  <= do_end;
    end
  end

  assign out_valid = out_valid_r;
  assign out_code  = out_code_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;

  assign stat.table_op   = (op_r != OP_KEY);
  assign stat.remap_nz   = (remap_q != '0);
  assign stat.is_layer   = (code_r == layer_key);
  assign stat.down       = (val_r != '0);
  assign stat.mapped     = (layer_q != '0);
  assign stat.is_mod     = mod_q;
  assign stat.mode       = mode_r;
  assign stat.sent       = sent_r;
  assign stat.count_zero = (count_r == '0);
  assign stat.out_block  = hold_v_r && out_valid_r && out_stall;

endmodule

// ===== sv/dual_role_layer_key_remapper_top.sv =====
// top level of the dual-role layer key remapper
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall  opcode, key code, key value, table data
//   out_     output     out_valid/out_stall out code, out value, last
//   cfg_     apb slave  psel/penable/pready layer key code at word 0
//
// the control program issues one step a cycle unless a stalled output holds it, and
// takes a new word only at its accept step, once the last event is done; each result
// passes through the single hold stage
// reset is synchronous and clears mode, queue pointers and the output register;
// a clearing pass then zeroes the tables with the input stalled
// a stalled output holds the sequencer only at a step that must move a word out

module dual_role_layer_key_remapper_top import drlkr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [OP_W-1:0]   in_opcode,
  input  logic [CODE_W-1:0] in_key_code,
  input  logic [VAL_W-1:0]  in_key_value,
  input  logic [CODE_W-1:0] in_table_data,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CODE_W-1:0] out_code,
  output logic [VAL_W-1:0]  out_value,
  output logic              out_last,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  ctrl_t             ctrl;
  stat_t             stat;
  logic              advance;
  logic              accept;
  logic [CODE_W-1:0] layer_key_r;
  logic              cfg_sel_reg;
  logic              tbl_rd_en;
  logic [CODE_W-1:0] tbl_rd_code;
  logic              tbl_wr_en;
  logic [OP_W-1:0]   tbl_wr_op;
  logic [CODE_W-1:0] tbl_wr_code;
  logic [CODE_W-1:0] tbl_wr_data;
  logic [CODE_W-1:0] remap_q;
  logic [CODE_W-1:0] layer_q;
  logic              mod_q;
  logic              tbl_busy;

  // configuration register, byte lane bits ignored
  assign cfg_pready  = 1'b1;
  assign cfg_sel_reg = (cfg_paddr[CFG_AW-1:2] == REG_LAYER_KEY);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layer_key_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_sel_reg) begin
      layer_key_r <= cfg_pwdata[CODE_W-1:0];
    end
  end

  assign cfg_prdata = cfg_sel_reg ? CFG_DW'(layer_key_r) : '0;

  // control program stepping, held at the accept step while the tables clear
  drlkr_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .busy     (tbl_busy),
    .stat     (stat),
    .ctrl     (ctrl),
    .advance  (advance),
    .accept   (accept),
    .in_stall (in_stall)
  );

  // event latch, layer state, pending queue and result staging
  drlkr_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_opcode     (in_opcode),
    .in_key_code   (in_key_code),
    .in_key_value  (in_key_value),
    .in_table_data (in_table_data),
    .accept        (accept),
    .advance       (advance),
    .ctrl          (ctrl),
    .layer_key     (layer_key_r),
    .remap_q       (remap_q),
    .layer_q       (layer_q),
    .mod_q         (mod_q),
    .rd_en         (tbl_rd_en),
    .rd_code       (tbl_rd_code),
    .wr_en         (tbl_wr_en),
    .wr_op         (tbl_wr_op),
    .wr_code       (tbl_wr_code),
    .wr_data       (tbl_wr_data),
    .stat          (stat),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_code      (out_code),
    .out_value     (out_value),
    .out_last      (out_last)
  );

  // lookup tables, read data one step behind the address
  drlkr_tables u_tables (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (tbl_rd_en),
    .rd_code (tbl_rd_code),
    .wr_en   (tbl_wr_en),
    .wr_op   (tbl_wr_op),
    .wr_code (tbl_wr_code),
    .wr_data (tbl_wr_data),
    .remap_q (remap_q),
    .layer_q (layer_q),
    .mod_q   (mod_q),
    .busy    (tbl_busy)
  );

endmodule

// ===== sv/drlkr_chk.sv =====
// port-level checks of the remapper and their bind to the top level
module drlkr_chk import drlkr_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic [OP_W-1:0]   in_opcode,
  input logic [CODE_W-1:0] in_key_code,
  input logic [VAL_W-1:0]  in_key_value,
  input logic [CODE_W-1:0] in_table_data,
  input logic              out_valid,
  input logic              out_stall,
  input logic [CODE_W-1:0] out_code,
  input logic [VAL_W-1:0]  out_value,
  input logic              out_last,
  input logic              cfg_psel,
  input logic              cfg_penable,
  input logic              cfg_pwrite,
  input logic [CFG_AW-1:0] cfg_paddr,
  input logic [CFG_DW-1:0] cfg_pwdata,
  input logic [CFG_DW-1:0] cfg_prdata,
  input logic              cfg_pready
);

  // reset empties the output register
  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a held result does not move
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable({out_code, out_value, out_last}))
    else $error("stalled result changed");

  // the sequencer is busy in the cycle after taking a word
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second word taken straight after the first");

  // the layer key register reads back what was written
  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && (cfg_paddr[CFG_AW-1:2] == '0)
    |=> (cfg_paddr[CFG_AW-1:2] != '0) ||
        (cfg_prdata == CFG_DW'($past(cfg_pwdata[CODE_W-1:0]))))
    else $error("layer key read-back mismatch");

endmodule

bind dual_role_layer_key_remapper_top drlkr_chk u_chk (.*);

// ===== bench/layer_key_checker.sv =====
// key value codes shared by the bench, and the checker that predicts and compares remapped words
package key_event_pkg;

  localparam logic [1:0] KEY_UP     = 2'd0;
  localparam logic [1:0] KEY_DOWN   = 2'd1;
  localparam logic [1:0] KEY_REPEAT = 2'd2;
  localparam logic [1:0] KEY_ODD    = 2'd3;

endpackage

module layer_key_checker import drlkr_pkg::*; import key_event_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [OP_W-1:0]   in_opcode,
  input  logic [CODE_W-1:0] in_key_code,
  input  logic [VAL_W-1:0]  in_key_value,
  input  logic [CODE_W-1:0] in_table_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [CODE_W-1:0] out_code,
  input  logic [VAL_W-1:0]  out_value,
  input  logic              out_last,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic              cfg_pready,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output int                pending_keys,
  output int                mismatches
);

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [VAL_W-1:0]  value;
    logic              last;
  } key_word_t;

  key_word_t         expected_keys[$];
  int                step_words;

  logic [CODE_W-1:0] layer_key;
  logic [1:0]        mode;
  logic              lk_sent;
  logic [CODE_W-1:0] held_codes[FIFO_DEPTH];
  int unsigned       held_count;
  int unsigned       held_head;
  logic [CODE_W-1:0] remap_tbl[CODE_COUNT];
  logic [CODE_W-1:0] layer_tbl[CODE_COUNT];
  logic              mod_flag[CODE_COUNT];

  function automatic logic [CODE_W-1:0] remap_of(input logic [CODE_W-1:0] code);
    return (int'(code) < CODE_COUNT) ? remap_tbl[code] : '0;
  endfunction

  function automatic logic [CODE_W-1:0] layer_of(input logic [CODE_W-1:0] code);
    return (int'(code) < CODE_COUNT) ? layer_tbl[code] : '0;
  endfunction

  function automatic void emit_key(input logic [CODE_W-1:0] code,
                                   input logic [VAL_W-1:0] value);
    key_word_t w;
    w.code  = code;
    w.value = value;
    w.last  = 1'b0;
    expected_keys.push_back(w);
    step_words++;
  endfunction

  // full queue drops the new code
  function automatic void push_held(input logic [CODE_W-1:0] code);
    if (held_count < FIFO_DEPTH) begin
      held_codes[(held_head + held_count) % FIFO_DEPTH] = code;
      held_count++;
    end
  endfunction

  function automatic logic [CODE_W-1:0] pop_held();
    logic [CODE_W-1:0] c;
    c = held_codes[held_head];
    held_head = (held_head + 1) % FIFO_DEPTH;
    held_count--;
    return c;
  endfunction

  task automatic translate_key(input logic [OP_W-1:0] op, input logic [CODE_W-1:0] code,
                               input logic [VAL_W-1:0] val, input logic [CODE_W-1:0] data);
    logic      down;
    logic      is_lk;
    logic      mapped;
    key_word_t w;
    down   = (val != KEY_UP);
    is_lk  = (code == layer_key);
    mapped = (layer_of(code) != '0);
    step_words = 0;
    if (op != OP_KEY) begin
      // table writes never touch the mode machine
      if (int'(code) < CODE_COUNT) begin
        case (op)
          OP_REMAP: remap_tbl[code] = data;
          OP_LAYER: layer_tbl[code] = data;
          default:  mod_flag[code]  = data[0];
        endcase
      end
    end else if (remap_of(code) != '0) begin
      emit_key(remap_of(code), val);
    end else begin
      case (mode)
        MODE_IDLE: begin
          if (is_lk && down) begin
            mode       = MODE_HELD;
            lk_sent    = 1'b0;
            held_count = 0;
            held_head  = 0;
          end else begin
            emit_key(code, val);
          end
        end
        MODE_HELD: begin
          if (is_lk) begin
            if (!down) begin
              mode = MODE_IDLE;
              if (!lk_sent) emit_key(layer_key, KEY_DOWN);
              emit_key(layer_key, KEY_UP);
            end
          end else if (mapped) begin
            if (down) begin
              mode = MODE_DELAY;
              push_held(code);
            end else begin
              emit_key(code, val);
            end
          end else begin
            if (!mod_flag[code] && down && !lk_sent) begin
              emit_key(layer_key, KEY_DOWN);
              lk_sent = 1'b1;
            end
            emit_key(code, val);
          end
        end
        MODE_DELAY: begin
          if (is_lk) begin
            if (!down) begin
              mode = MODE_IDLE;
              if (!lk_sent) emit_key(layer_key, KEY_DOWN);
              while (held_count != 0) emit_key(pop_held(), KEY_DOWN);
              emit_key(layer_key, KEY_UP);
            end
          end else if (mapped) begin
            mode = MODE_MAPPED;
            if (down) begin
              if (held_count != 0) emit_key(layer_of(held_codes[held_head]), KEY_DOWN);
              push_held(code);
            end else begin
              while (held_count != 0) emit_key(layer_of(pop_held()), KEY_DOWN);
            end
            emit_key(layer_of(code), val);
          end else begin
            mode = MODE_MAPPED;
            emit_key(code, val);
          end
        end
        default: begin
          if (is_lk) begin
            if (!down) begin
              mode = MODE_IDLE;
              while (held_count != 0) emit_key(layer_of(pop_held()), KEY_UP);
            end
          end else if (mapped) begin
            if (down) push_held(code);
            emit_key(layer_of(code), val);
          end else begin
            emit_key(code, val);
          end
        end
      endcase
    end
    if (step_words != 0) begin
      w = expected_keys.pop_back();
      w.last = 1'b1;
      expected_keys.push_back(w);
    end
  endtask

  always @(posedge clk) begin
    key_word_t want;
    if (!rst_n) begin
      expected_keys.delete();
      layer_key  = '0;
      mode       = MODE_IDLE;
      lk_sent    = 1'b0;
      held_count = 0;
      held_head  = 0;
      mismatches = 0;
      for (int i = 0; i < CODE_COUNT; i++) begin
        remap_tbl[i] = '0;
        layer_tbl[i] = '0;
        mod_flag[i]  = 1'b0;
      end
    end else begin
      // words leaving now belong to earlier events, so compare first
      if (out_valid && !out_stall) begin
        if (expected_keys.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected word, expected none, got code %0h value %0d last %0b",
                   $time, out_code, out_value, out_last);
        end else begin
          want = expected_keys.pop_front();
          if (out_code != want.code) begin
            mismatches++;
            $display("%0t: code mismatch, expected %0h, got %0h", $time, want.code, out_code);
          end
          if (out_value != want.value) begin
            mismatches++;
            $display("%0t: value mismatch, expected %0d, got %0d", $time, want.value,
                     out_value);
          end
          if (out_last != want.last) begin
            mismatches++;
            $display("%0t: last mismatch, expected %0b, got %0b", $time, want.last, out_last);
          end
        end
      end
      if (in_valid && !in_stall)
        translate_key(in_opcode, in_key_code, in_key_value, in_table_data);
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr[CFG_AW-1:2] == REG_LAYER_KEY)
        layer_key = cfg_pwdata[CODE_W-1:0];
    end
    pending_keys <= expected_keys.size();
  end

endmodule

// ===== bench/testbench.sv =====
// stimulus, stall pattern, watchdog and verdict for the dual-role layer key remapper
module testbench;
  import drlkr_pkg::*;
  import key_event_pkg::*;

  // longest correct stretch with no handshake: the table clearing pass after reset,
  // an output stall burst on top of a flush of the pending queue, or the settle
  // before a register write; the limit lies well above each of these
  localparam int WATCHDOG_LIMIT = 2000;
  // settle time after the last expected word, covering events that emit nothing
  localparam int SETTLE_CYCLES  = 40;
  localparam int PHASE_ITEMS    = 95;
  localparam int POOL_SIZE      = 8;

  logic              clk           = 1'b0;
  logic              rst_n         = 1'b0;
  logic              in_valid      = 1'b0;
  logic              in_stall;
  logic [OP_W-1:0]   in_opcode     = OP_KEY;
  logic [CODE_W-1:0] in_key_code   = '0;
  logic [VAL_W-1:0]  in_key_value  = KEY_UP;
  logic [CODE_W-1:0] in_table_data = '0;
  logic              out_valid;
  logic              out_stall     = 1'b0;
  logic [CODE_W-1:0] out_code;
  logic [VAL_W-1:0]  out_value;
  logic              out_last;
  logic              cfg_psel      = 1'b0;
  logic              cfg_penable   = 1'b0;
  logic              cfg_pwrite    = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr     = '0;
  logic [CFG_DW-1:0] cfg_pwdata    = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  int pending_keys;
  int mismatches;
  int idle_pct    = 0;   // chance in percent that either side starts an idle burst
  int stall_left  = 0;
  int quiet_count = 0;
  int sent_items  = 0;

  logic [CODE_W-1:0] lk_code = '0;   // layer key currently programmed
  logic [CODE_W-1:0] key_pool[POOL_SIZE] = '{8'h10, 8'h11, 8'h12, 8'h13,
                                             8'h14, 8'h15, 8'h16, 8'h17};

  dual_role_layer_key_remapper_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_opcode(in_opcode),
    .in_key_code(in_key_code), .in_key_value(in_key_value), .in_table_data(in_table_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_code(out_code),
    .out_value(out_value), .out_last(out_last),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  layer_key_checker key_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_opcode(in_opcode),
    .in_key_code(in_key_code), .in_key_value(in_key_value), .in_table_data(in_table_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_code(out_code),
    .out_value(out_value), .out_last(out_last),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_pready(cfg_pready), .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata),
    .pending_keys(pending_keys), .mismatches(mismatches)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver stall: random bursts, none started while idle_pct is zero
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (rst_n && idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(14);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog: any accepted word on any port restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_psel && cfg_penable && cfg_pready)) begin
      quiet_count <= 0;
    end else if (quiet_count >= WATCHDOG_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  // one input word; valid stays high afterwards unless an idle burst follows,
  // so callers that stop sending must lower it themselves
  task automatic send_word(input logic [OP_W-1:0] op, input logic [CODE_W-1:0] code,
                           input logic [VAL_W-1:0] val, input logic [CODE_W-1:0] data);
    in_opcode     <= op;
    in_key_code   <= code;
    in_key_value  <= val;
    in_table_data <= data;
    in_valid      <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_items++;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(15, 1)) @(posedge clk);
    end
  endtask

  // key event with junk in the unused data field
  task automatic key(input logic [CODE_W-1:0] code, input logic [VAL_W-1:0] val);
    send_word(OP_KEY, code, val, CODE_W'($urandom_range(255)));
  endtask

  // wait for every expected word plus settle time, then program the layer key
  task automatic write_layer_key(input logic [CODE_W-1:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_keys != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {REG_LAYER_KEY, 2'b00};
    cfg_pwdata  <= CFG_DW'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    lk_code = value;
  endtask

  // mostly presses, some releases, repeats and the odd value 3
  function automatic logic [VAL_W-1:0] pick_value();
    int p;
    p = $urandom_range(99);
    if (p < 70) return KEY_DOWN;
    if (p < 85) return KEY_UP;
    if (p < 95) return KEY_REPEAT;
    return KEY_ODD;
  endfunction

  function automatic int pick_idle();
    int p;
    p = $urandom_range(3);
    return (p == 0) ? 0 : (p == 1) ? 10 : (p == 2) ? 25 : 40;
  endfunction

  // layer key held over a run of mostly layer-mapped keys, usually released at the end
  task automatic play_chord();
    int                n;
    int                p;
    logic [CODE_W-1:0] code;
    n = $urandom_range(12, 1);
    key(lk_code, ($urandom_range(7) == 0) ? KEY_REPEAT : KEY_DOWN);
    repeat (n) begin
      p = $urandom_range(99);
      if (p < 70)      code = key_pool[$urandom_range(POOL_SIZE - 1)];
      else if (p < 76) code = lk_code;
      else             code = CODE_W'($urandom_range(255));
      key(code, pick_value());
    end
    if ($urandom_range(9) != 0) key(lk_code, KEY_UP);
  endtask

  task automatic table_write();
    int                p;
    logic [CODE_W-1:0] code;
    logic [CODE_W-1:0] data;
    p    = $urandom_range(99);
    code = ($urandom_range(1) == 0) ? key_pool[$urandom_range(POOL_SIZE - 1)]
                                    : CODE_W'($urandom_range(255));
    data = CODE_W'($urandom_range(255));
    if (p < 60) begin
      send_word(OP_LAYER, code, VAL_W'($urandom_range(3)), data);
    end else if (p < 80) begin
      // half the remap writes clear an entry again
      send_word(OP_REMAP, code, VAL_W'($urandom_range(3)),
                ($urandom_range(1) == 0) ? '0 : data);
    end else begin
      send_word(OP_MOD, code, VAL_W'($urandom_range(3)), data);
    end
  endtask

  task automatic random_phase(input logic [CODE_W-1:0] layer_key, input logic calm);
    int target;
    int p;
    write_layer_key(layer_key);
    idle_pct = calm ? 0 : pick_idle();
    target   = sent_items + PHASE_ITEMS;
    // give the pool fresh layer entries so chords reach the mapped states
    foreach (key_pool[i])
      send_word(OP_LAYER, key_pool[i], VAL_W'($urandom_range(3)),
                CODE_W'($urandom_range(255, 1)));
    while (sent_items < target) begin
      if (!calm && $urandom_range(19) == 0) idle_pct = pick_idle();
      p = $urandom_range(99);
      if (p < 55) begin
        play_chord();
      end else if (p < 70) begin
        key(lk_code, KEY_DOWN);
        key(lk_code, KEY_UP);
      end else if (p < 85) begin
        key(CODE_W'($urandom_range(255)), VAL_W'($urandom_range(3)));
      end else begin
        table_write();
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed part, layer key 3a
    write_layer_key(8'h3A);
    send_word(OP_LAYER, 8'h10, KEY_UP, 8'h50);
    send_word(OP_LAYER, 8'h11, KEY_UP, 8'hFF);
    send_word(OP_REMAP, 8'h30, KEY_UP, 8'hFF);
    send_word(OP_MOD,   8'h20, KEY_UP, 8'h01);
    key(8'h00, KEY_DOWN);            // idle pass-through, lowest code
    key(8'hFF, KEY_ODD);             // value 3 forwarded untouched
    key(8'h30, KEY_REPEAT);          // remap entry wins
    key(8'h3A, KEY_DOWN);            // plain tap of the layer key
    key(8'h3A, KEY_UP);
    key(8'h3A, KEY_DOWN);            // hold with unmapped keys
    key(8'h3A, KEY_REPEAT);          // layer key again while active: ignored
    key(8'h20, KEY_DOWN);            // modifier does not send the layer key
    key(8'h44, KEY_DOWN);            // plain key sends the layer key first
    key(8'h10, KEY_UP);              // mapped release while held passes through
    key(8'h3A, KEY_UP);
    key(8'h3A, KEY_DOWN);            // mapped press then release in delay
    key(8'h10, KEY_DOWN);
    key(8'h3A, KEY_UP);
    key(8'h3A, KEY_DOWN);            // fill the pending queue past full
    key(8'h10, KEY_DOWN);
    key(8'h11, KEY_DOWN);
    repeat (7) key(8'h11, KEY_DOWN);
    key(8'h3A, KEY_UP);

    // random phases over the layer key extremes, random keys and 3a, the last with no idling
    random_phase(8'h00, 1'b0);
    random_phase(8'hFF, 1'b0);
    random_phase(CODE_W'($urandom_range(255)), 1'b0);
    random_phase(CODE_W'($urandom_range(255)), 1'b0);
    random_phase(8'h3A, 1'b1);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_keys != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/drlkr_pkg.sv
sv/drlkr_ram.sv
sv/drlkr_tables.sv
sv/drlkr_seq.sv
sv/drlkr_dp.sv
sv/dual_role_layer_key_remapper_top.sv
sv/drlkr_chk.sv
bench/layer_key_checker.sv
bench/testbench.sv
